### rtl/core/nbtl_pkg.sv
package nbtl_pkg;

   localparam logic [1:0] REQ_PUSH  = 2'd0;
   localparam logic [1:0] REQ_QUERY = 2'd1;
   localparam logic [1:0] REQ_READ  = 2'd2;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_INVALID  = 2'd1;
   localparam logic [1:0] ST_DROPPED  = 2'd2;
   localparam logic [1:0] ST_NOTFOUND = 2'd3;

   localparam logic [1:0] CSR_TIME_LIMIT = 2'd0;
   localparam logic [1:0] CSR_MIN_GRAMS  = 2'd1;
   localparam logic [1:0] CSR_MAX_GRAMS  = 2'd2;

   typedef struct packed {
      logic [31:0] t;
      logic [15:0] ty;
      logic [15:0] g;
   } entry_type;

   // controller -> datapath
   typedef struct packed {
      logic load;       // latch request
      logic rd_issue;   // issue memory read at scan pointer
      logic wr_shift;   // write last read entry at pointer+1
      logic wr_new;     // write new entry at pointer
      logic wr_new_up;  // write new entry at pointer+1
      logic drop_head;  // eviction: move entry down to pointer-1
      logic ptr_dec;
      logic ptr_inc;
      logic ptr_set_top;
      logic ptr_set_zero;
      logic cnt_inc;
      logic cnt_dec;
      logic rsp_fire;
      logic [1:0] rsp_status;
      logic rsp_entry;  // output last read entry
      logic rsp_grams;  // output last read grams only
   } ctl_type;

   // datapath -> controller
   typedef struct packed {
      logic [1:0] req;
      logic push_bad;
      logic idx_ok;
      logic cnt_zero;
      logic full;
      logic ptr_zero;
      logic ptr_last;   // ptr == count-1
      logic rd_gt;      // read entry time > new time
      logic rd_match;   // read entry matches query
      logic new_older;  // new time < read entry time
   } sts_type;

endpackage

### rtl/core/nbtl_ctrl.sv
module nbtl_ctrl
   import nbtl_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  sts_type sts,
   output ctl_type ctl
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DEC    = 4'd1;
   localparam logic [3:0] S_EV_RD  = 4'd2;  // read head for drop check
   localparam logic [3:0] S_EV_CHK = 4'd3;
   localparam logic [3:0] S_EV_SH  = 4'd4;  // shift entries down one place at a time
   localparam logic [3:0] S_EV_WT  = 4'd5;
   localparam logic [3:0] S_IN_RD  = 4'd6;
   localparam logic [3:0] S_IN_CHK = 4'd7;
   localparam logic [3:0] S_Q_RD   = 4'd8;
   localparam logic [3:0] S_Q_CHK  = 4'd9;
   localparam logic [3:0] S_R_RD   = 4'd10;
   localparam logic [3:0] S_R_OUT  = 4'd11;
   localparam logic [3:0] S_IN_WR  = 4'd12;  // new entry into position 0

   logic [3:0] state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      ctl = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               ctl.load = 1'b1;
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            case (sts.req)
               REQ_PUSH: begin
                  if (sts.push_bad) begin
                     ctl.rsp_fire = 1'b1;
                     ctl.rsp_status = ST_INVALID;
                     state_in = S_IDLE;
                  end else if (sts.full) begin
                     ctl.ptr_set_zero = 1'b1;
                     state_in = S_EV_RD;
                  end else if (sts.cnt_zero) begin
                     ctl.ptr_set_zero = 1'b1;
                     state_in = S_IN_RD;
                  end else begin
                     ctl.ptr_set_top = 1'b1;
                     state_in = S_IN_RD;
                  end
               end
               REQ_QUERY: begin
                  if (sts.push_bad || sts.cnt_zero) begin
                     // push_bad carries "type zero" for a query
                     ctl.rsp_fire = 1'b1;
                     ctl.rsp_status = ST_NOTFOUND;
                     state_in = S_IDLE;
                  end else begin
                     ctl.ptr_set_top = 1'b1;
                     state_in = S_Q_RD;
                  end
               end
               REQ_READ: begin
                  if (sts.idx_ok) state_in = S_R_RD;
                  else begin
                     ctl.rsp_fire = 1'b1;
                     ctl.rsp_status = ST_NOTFOUND;
                     state_in = S_IDLE;
                  end
               end
               default: begin
                  ctl.rsp_fire = 1'b1;
                  ctl.rsp_status = ST_NOTFOUND;
                  state_in = S_IDLE;
               end
            endcase
         end
         S_EV_RD: begin
            ctl.rd_issue = 1'b1;
            state_in = S_EV_CHK;
         end
         S_EV_CHK: begin
            if (sts.new_older) begin
               ctl.rsp_fire = 1'b1;
               ctl.rsp_status = ST_DROPPED;
               state_in = S_IDLE;
            end else begin
               ctl.ptr_inc = 1'b1;
               state_in = S_EV_SH;
            end
         end
         S_EV_SH: begin
            // read entry at ptr
            ctl.rd_issue = 1'b1;
            state_in = S_EV_WT;
         end
         S_EV_WT: begin
            ctl.drop_head = 1'b1;
            if (sts.ptr_last) begin
               ctl.cnt_dec = 1'b1;
               ctl.ptr_dec = 1'b1;  // top of shortened table
               state_in = S_IN_RD;
            end else begin
               ctl.ptr_inc = 1'b1;
               state_in = S_EV_SH;
            end
         end
         S_IN_RD: begin
            if (sts.cnt_zero) begin
               ctl.wr_new = 1'b1;
               ctl.cnt_inc = 1'b1;
               ctl.rsp_fire = 1'b1;
               ctl.rsp_status = ST_OK;
               state_in = S_IDLE;
            end else begin
               ctl.rd_issue = 1'b1;
               state_in = S_IN_CHK;
            end
         end
         S_IN_CHK: begin
            if (sts.rd_gt) begin
               ctl.wr_shift = 1'b1;
               if (sts.ptr_zero) begin
                  state_in = S_IN_WR;
               end else begin
                  ctl.ptr_dec = 1'b1;
                  state_in = S_IN_RD;
               end
            end else begin
               ctl.wr_new_up = 1'b1;
               ctl.cnt_inc = 1'b1;
               ctl.rsp_fire = 1'b1;
               ctl.rsp_status = ST_OK;
               state_in = S_IDLE;
            end
         end
         S_IN_WR: begin
            // everything shifted: new entry lands at position 0
            ctl.wr_new = 1'b1;
            ctl.cnt_inc = 1'b1;
            ctl.rsp_fire = 1'b1;
            ctl.rsp_status = ST_OK;
            state_in = S_IDLE;
         end
         S_Q_RD: begin
            ctl.rd_issue = 1'b1;
            state_in = S_Q_CHK;
         end
         S_Q_CHK: begin
            if (sts.rd_match) begin
               ctl.rsp_fire = 1'b1;
               ctl.rsp_status = ST_OK;
               ctl.rsp_grams = 1'b1;
               state_in = S_IDLE;
            end else if (sts.ptr_zero) begin
               ctl.rsp_fire = 1'b1;
               ctl.rsp_status = ST_NOTFOUND;
               state_in = S_IDLE;
            end else begin
               ctl.ptr_dec = 1'b1;
               state_in = S_Q_RD;
            end
         end
         S_R_RD: begin
            // entry at the index was read into rd_ff when the request was loaded
            state_in = S_R_OUT;
         end
         S_R_OUT: begin
            ctl.rsp_fire = 1'b1;
            ctl.rsp_status = ST_OK;
            ctl.rsp_entry = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   a_busy_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("start not taken");
   a_fire_busy: assert property (@(posedge clock) disable iff (reset)
      ctl.rsp_fire |-> busy)
      else $error("response while idle");
   a_no_double_wr: assert property (@(posedge clock) disable iff (reset)
      !(ctl.wr_new && ctl.wr_shift))
      else $error("two memory writes");

endmodule

### rtl/core/nbtl_dp.sv
module nbtl_dp
   import nbtl_pkg::*;
#(
   parameter int DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  ctl_type     ctl,
   output sts_type     sts,
   input  logic [1:0]  req_type,
   input  logic [31:0] req_entry_time,
   input  logic [15:0] req_entry_type,
   input  logic [15:0] req_entry_grams,
   input  logic [7:0]  req_entry_index,
   input  logic        csr_valid,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [8:0]  rsp_stored_count,
   output logic [31:0] rsp_out_time,
   output logic [15:0] rsp_out_type,
   output logic [15:0] rsp_out_grams
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [31:0] time_limit_ff;
   logic [15:0] min_grams_ff, max_grams_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         time_limit_ff <= '1;
         min_grams_ff  <= 16'd1;
         max_grams_ff  <= '1;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_TIME_LIMIT: time_limit_ff <= csr_data;
            CSR_MIN_GRAMS:  min_grams_ff  <= csr_data[15:0];
            CSR_MAX_GRAMS:  max_grams_ff  <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   logic [1:0]  req_ff;
   entry_type   new_ff;
   logic [7:0]  idx_ff;
   logic [CW-1:0] cnt_ff;
   logic [AW-1:0] ptr_ff;
   entry_type   rd_ff;
   entry_type   mem [DEPTH];

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         req_ff   <= req_type;
         new_ff.t <= req_entry_time;
         new_ff.ty <= req_entry_type;
         new_ff.g <= req_entry_grams;
         idx_ff   <= req_entry_index;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         ptr_ff <= '0;
      end else begin
         if (ctl.cnt_inc)      cnt_ff <= cnt_ff + 1'b1;
         else if (ctl.cnt_dec) cnt_ff <= cnt_ff - 1'b1;
         if (ctl.ptr_set_zero)     ptr_ff <= '0;
         else if (ctl.ptr_set_top) ptr_ff <= AW'(cnt_ff - 1'b1);
         else if (ctl.ptr_inc)     ptr_ff <= ptr_ff + 1'b1;
         else if (ctl.ptr_dec)     ptr_ff <= ptr_ff - 1'b1;
      end
   end

   // one write port, one read port
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   entry_type     wr_data;

   always_comb begin
      wr_en = 1'b0;
      wr_addr = ptr_ff;
      wr_data = new_ff;
      if (ctl.wr_new) begin
         wr_en = 1'b1;
      end else if (ctl.wr_new_up) begin
         wr_en = 1'b1;
         wr_addr = ptr_ff + 1'b1;
      end else if (ctl.wr_shift) begin
         wr_en = 1'b1;
         wr_addr = ptr_ff + 1'b1;
         wr_data = rd_ff;
      end else if (ctl.drop_head) begin
         wr_en = 1'b1;
         wr_addr = ptr_ff - 1'b1;
         wr_data = rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (ctl.rd_issue) rd_ff <= mem[ptr_ff];
      else if (ctl.load) rd_ff <= mem[AW'(req_entry_index)];
   end

   always_comb begin
      sts.req       = req_ff;
      sts.push_bad  = (req_ff == REQ_PUSH)
                    ? (new_ff.t == '0 || new_ff.t >= time_limit_ff ||
                       new_ff.g < min_grams_ff || new_ff.g > max_grams_ff ||
                       new_ff.ty == '0)
                    : (new_ff.ty == '0);
      sts.idx_ok    = ({{(CW > 8 ? CW - 8 : 0){1'b0}}, idx_ff} < cnt_ff);
      sts.cnt_zero  = (cnt_ff == '0);
      sts.full      = (cnt_ff >= CW'(DEPTH));
      sts.ptr_zero  = (ptr_ff == '0);
      sts.ptr_last  = (CW'(ptr_ff) == cnt_ff - 1'b1);
      sts.rd_gt     = (rd_ff.t > new_ff.t);
      sts.rd_match  = (rd_ff.ty == new_ff.ty) && (rd_ff.g != '0);
      sts.new_older = (new_ff.t < rd_ff.t);
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else       rsp_valid <= ctl.rsp_fire;
   end

   always_ff @(posedge clock) begin
      if (ctl.rsp_fire) begin
         rsp_status    <= ctl.rsp_status;
         rsp_stored_count <= 9'((ctl.cnt_inc ? cnt_ff + 1'b1 : {1'b0, cnt_ff}));
         rsp_out_time  <= ctl.rsp_entry ? rd_ff.t : '0;
         rsp_out_type  <= ctl.rsp_entry ? rd_ff.ty : '0;
         rsp_out_grams <= (ctl.rsp_entry || ctl.rsp_grams) ? rd_ff.g : '0;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(DEPTH))
      else $error("count over depth");
   a_cnt_step: assert property (@(posedge clock) disable iff (reset)
      ctl.cnt_inc |=> cnt_ff == $past(cnt_ff) + 1'b1)
      else $error("count step");
   a_one_wr: assert property (@(posedge clock) disable iff (reset)
      $countones({ctl.wr_new, ctl.wr_new_up, ctl.wr_shift, ctl.drop_head}) <= 1)
      else $error("write conflict");

endmodule

### rtl/core/newest_by_time_bounded_log_top.sv
// Sorted log of up to DEPTH (time, type, grams) entries, oldest first. One request is
// taken at a time while busy is low; its single response appears on rsp_valid for one
// cycle and must be captured then. Time is set by the entry memory, walked one entry
// at a time. A rejected push, a query of type zero or on an empty table, a read out of
// range and an unused selector are answered straight from decode; a query scans entries
// from the newest down, and a push moves entries with a later time up one place until
// its slot is found. In a full table a push older than the oldest entry is dropped;
// otherwise the oldest is evicted by shifting every entry down before the insert.
// busy drops at the edge where rsp_valid rises, so the next request can be taken in
// that cycle.
module newest_by_time_bounded_log_top
   import nbtl_pkg::*;
#(
   parameter int DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_type,
   input  logic [31:0] req_entry_time,
   input  logic [15:0] req_entry_type,
   input  logic [15:0] req_entry_grams,
   input  logic [7:0]  req_entry_index,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [8:0]  rsp_stored_count,
   output logic [31:0] rsp_out_time,
   output logic [15:0] rsp_out_type,
   output logic [15:0] rsp_out_grams
);

   ctl_type ctl;
   sts_type sts;

   assign csr_ready = 1'b1;

   nbtl_ctrl u_ctrl (
      .clock, .reset, .start, .busy, .sts, .ctl
   );

   nbtl_dp #(.DEPTH(DEPTH)) u_dp (
      .clock, .reset, .ctl, .sts,
      .req_type, .req_entry_time, .req_entry_type, .req_entry_grams, .req_entry_index,
      .csr_valid, .csr_index, .csr_data,
      .rsp_valid, .rsp_status, .rsp_stored_count,
      .rsp_out_time, .rsp_out_type, .rsp_out_grams
   );

endmodule
